/* design/lrwg_pkg.sv */
// ----------------------------------------------------------------------------
// lrwg_pkg
// Shared types, codes and constants of the link-rate workload governor.
// ----------------------------------------------------------------------------
package lrwg_pkg;

    // Widths of the fixed fields
    localparam int GEN_W      = 3;
    localparam int LANE_W     = 3;
    localparam int OPCODE_W   = 2;
    localparam int KIND_W     = 2;
    localparam int BYTES_W    = 32;
    localparam int THR_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    // Byte total width, default for the top level parameter
    localparam int TOTAL_BITS_DEF = 64;

    // KB conversion is a plain shift
    localparam int KB_DIV   = 1024;
    localparam int KB_SHIFT = $clog2(KB_DIV);

    // Threshold arithmetic
    localparam int BW_W          = 16;
    localparam int RETRAIN_SCALE = 10;
    localparam int DVS_W         = 20;   // 10 * (hi - lo) stays below 2^20
    localparam int DVD_W         = 32;   // lo * hi + divisor / 2 stays below 2^32
    localparam int REM_W         = DVS_W + 1;
    localparam int DIV_STEPS     = THR_W;
    localparam int STEP_CNT_W    = $clog2(DIV_STEPS);
    localparam logic [THR_W-1:0] THR_MAX = 13'd6400;

    // Bandwidth table: row = generation - 1, column = lane width code
    localparam int GEN_COUNT  = 5;
    localparam int LANE_COUNT = 5;
    localparam logic [GEN_W-1:0]  GEN_LO   = 3'd1;
    localparam logic [GEN_W-1:0]  GEN_HI   = 3'd5;
    localparam logic [LANE_W-1:0] LANE_MAX = 3'd4;

    localparam logic [BW_W-1:0] BW_TABLE [GEN_COUNT][LANE_COUNT] = '{
        '{16'd312,  16'd625,  16'd1250,  16'd2500,  16'd5000},
        '{16'd625,  16'd1250, 16'd2500,  16'd5000,  16'd10000},
        '{16'd1000, 16'd2000, 16'd4000,  16'd8000,  16'd16000},
        '{16'd2000, 16'd4000, 16'd8000,  16'd16000, 16'd32000},
        '{16'd4000, 16'd8000, 16'd16000, 16'd32000, 16'd64000}
    };

    // Reset configuration and the threshold that follows from it
    localparam logic [GEN_W-1:0]  RESET_MIN_GEN = 3'd1;
    localparam logic [GEN_W-1:0]  RESET_MAX_GEN = 3'd5;
    localparam logic [LANE_W-1:0] RESET_LANE    = 3'd2;
    localparam logic [THR_W-1:0]  RESET_THR     = 13'd136;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_GEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_GEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LANE    = 2'd2;

    // Item opcodes
    localparam logic [OPCODE_W-1:0] OP_IO      = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_TICK    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_OUTCOME = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_START   = 2'd3;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;

    // Retraining phase
    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_RETRAIN  = 2'd1;
    localparam logic [1:0] PH_ROLLBACK = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic accept;     // apply the accepted item
        logic prep;       // table lookup, load divider
        logic div_step;   // one quotient bit
        logic finish;     // store threshold, arm window
        logic load_out;   // capture result item
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic need_div;   // item arms the window: threshold needed
        logic cfg_ok;     // settings give a nonzero-range threshold
    } t_dp_sts;

endpackage

/* design/lrwg_if.sv */
// ----------------------------------------------------------------------------
// lrwg_if
// Channel interfaces: input items, result items and register writes.
// ----------------------------------------------------------------------------
interface lrwg_in_if;
    logic                              valid;
    logic                              ready;
    logic [lrwg_pkg::OPCODE_W-1:0]     opcode;
    logic [lrwg_pkg::KIND_W-1:0]       io_kind;
    logic [lrwg_pkg::BYTES_W-1:0]      io_bytes;
    logic                              retrain_ok;

    modport source (output valid, opcode, io_kind, io_bytes, retrain_ok, input ready);
    modport sink   (input valid, opcode, io_kind, io_bytes, retrain_ok, output ready);
endinterface

interface lrwg_res_if;
    logic                          valid;
    logic                          ready;
    logic                          switch_request;
    logic [lrwg_pkg::GEN_W-1:0]    request_gen;
    logic [lrwg_pkg::GEN_W-1:0]    current_gen_out;
    logic                          active_flag;
    logic                          window_flag;
    logic [lrwg_pkg::THR_W-1:0]    threshold_kb;

    modport source (output valid, switch_request, request_gen, current_gen_out,
                    active_flag, window_flag, threshold_kb, input ready);
    modport sink   (input valid, switch_request, request_gen, current_gen_out,
                    active_flag, window_flag, threshold_kb, output ready);
endinterface

interface lrwg_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [lrwg_pkg::CFG_IDX_W-1:0]    index;
    logic [lrwg_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* design/link_rate_workload_governor.sv */
// ----------------------------------------------------------------------------
// link_rate_workload_governor
// Picks a link generation from windowed read/write traffic and requests
// retraining, with rollback on failure.
// ----------------------------------------------------------------------------
// Every input item yields exactly one result item. For most items the result
// register is loaded at acceptance and the next item is taken in the
// following cycle provided the result has been taken (or is taken in the
// same cycle). The exception is a counted I/O request that arms the window:
// it recomputes the KB threshold round(lo*hi / (10*(hi-lo))) from the
// bandwidth table: table lookup and the 16x16 multiply, then the
// one-bit-per-cycle restoring divider, then storing the threshold and
// loading the result; the divider is skipped for unusable settings. No
// further item is taken while that runs. Register writes are taken at any
// time (ready is always high) but are only to be issued with the block idle;
// the threshold is only recomputed when the window is armed by traffic.
// ----------------------------------------------------------------------------
module link_rate_workload_governor #(
    parameter int TOTAL_BITS = lrwg_pkg::TOTAL_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lrwg_in_if.sink     i_in,
    lrwg_res_if.source  o_out,
    lrwg_cfg_if.sink    i_cfg
);

    lrwg_pkg::t_dp_cmd  cmd;
    lrwg_pkg::t_dp_sts  sts;

    // register writes never stall
    assign i_cfg.ready = 1'b1;

    // Sequencer: owns both handshakes and the divider step count
    lrwg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Datapath: state, totals, divider, result payload
    lrwg_dp #(
        .TOTAL_BITS (TOTAL_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg.valid),
        .i_cfg_index       (i_cfg.index),
        .i_cfg_data        (i_cfg.data),
        .i_opcode          (i_in.opcode),
        .i_io_kind         (i_in.io_kind),
        .i_io_bytes        (i_in.io_bytes),
        .i_retrain_ok      (i_in.retrain_ok),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_switch_request  (o_out.switch_request),
        .o_request_gen     (o_out.request_gen),
        .o_current_gen_out (o_out.current_gen_out),
        .o_active_flag     (o_out.active_flag),
        .o_window_flag     (o_out.window_flag),
        .o_threshold_kb    (o_out.threshold_kb)
    );

endmodule

/* design/lrwg_ctrl.sv */
// ----------------------------------------------------------------------------
// lrwg_ctrl
// Sequencer: handshakes, threshold computation steps, result register valid.
// ----------------------------------------------------------------------------
module lrwg_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  lrwg_pkg::t_dp_sts  i_sts,
    output lrwg_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PREP = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state                              r_state, n_state;
    logic [lrwg_pkg::STEP_CNT_W-1:0]     r_cnt, n_cnt;
    logic                                r_out_valid, n_out_valid;
    logic                                out_free;
    logic                                accept;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && out_free;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.need_div) begin
                        n_state = S_PREP;
                    end else begin
                        o_cmd.load_out = 1'b1;
                    end
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_cnt      = lrwg_pkg::STEP_CNT_W'(lrwg_pkg::DIV_STEPS - 1);
                n_state    = i_sts.cfg_ok ? S_DIV : S_DONE;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // result register drained on acceptance, so it is free here
                o_cmd.finish   = 1'b1;
                o_cmd.load_out = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* design/lrwg_dp.sv */
// ----------------------------------------------------------------------------
// lrwg_dp
// Datapath: configuration, byte totals, generation state, threshold divider
// and the result register.
// ----------------------------------------------------------------------------
module lrwg_dp #(
    parameter int TOTAL_BITS = lrwg_pkg::TOTAL_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // register writes
    input  logic                              i_cfg_we,
    input  logic [lrwg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lrwg_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // item payload
    input  logic [lrwg_pkg::OPCODE_W-1:0]     i_opcode,
    input  logic [lrwg_pkg::KIND_W-1:0]       i_io_kind,
    input  logic [lrwg_pkg::BYTES_W-1:0]      i_io_bytes,
    input  logic                              i_retrain_ok,
    // control
    input  lrwg_pkg::t_dp_cmd                 i_cmd,
    output lrwg_pkg::t_dp_sts                 o_sts,
    // result payload
    output logic                              o_switch_request,
    output logic [lrwg_pkg::GEN_W-1:0]        o_request_gen,
    output logic [lrwg_pkg::GEN_W-1:0]        o_current_gen_out,
    output logic                              o_active_flag,
    output logic                              o_window_flag,
    output logic [lrwg_pkg::THR_W-1:0]        o_threshold_kb
);

    localparam int KB_W = TOTAL_BITS - lrwg_pkg::KB_SHIFT;

    // configuration
    logic [lrwg_pkg::GEN_W-1:0]   r_min_gen, r_max_gen;
    logic [lrwg_pkg::LANE_W-1:0]  r_lane;

    // governor state
    logic [TOTAL_BITS-1:0]        r_rd_tot, n_rd_tot, r_wr_tot, n_wr_tot;
    logic [lrwg_pkg::GEN_W-1:0]   r_cur_gen, n_cur_gen, r_tgt_gen, n_tgt_gen;
    logic                         r_gov_on, n_gov_on, r_armed, n_armed;
    logic [1:0]                   r_phase, n_phase;
    logic [lrwg_pkg::THR_W-1:0]   r_thr, n_thr;

    // divider
    logic                         r_cfg_ok;
    logic [lrwg_pkg::REM_W-1:0]   r_rem;
    logic [lrwg_pkg::THR_W-1:0]   r_dvd_lo;
    logic [lrwg_pkg::DVS_W-1:0]   r_dvs;
    logic [lrwg_pkg::THR_W-1:0]   r_quo;

    // result register
    logic                         r_o_req;
    logic [lrwg_pkg::GEN_W-1:0]   r_o_req_gen, r_o_cur_gen;
    logic                         r_o_act, r_o_win;
    logic [lrwg_pkg::THR_W-1:0]   r_o_thr;

    logic                         kind_counted;
    logic [TOTAL_BITS:0]          rd_sum, wr_sum;
    logic [TOTAL_BITS-1:0]        rd_sat, wr_sat;
    logic                         hit;
    logic [lrwg_pkg::GEN_W-1:0]   pick;
    logic                         req;
    logic [lrwg_pkg::GEN_W-1:0]   req_gen;

    // threshold preparation
    logic                         min_ok, max_ok, lane_ok;
    logic [lrwg_pkg::GEN_W-1:0]   min_idx, max_idx;
    logic [lrwg_pkg::LANE_W-1:0]  lane_idx;
    logic [lrwg_pkg::BW_W-1:0]    bw_lo, bw_hi, bw_diff;
    logic [lrwg_pkg::DVD_W-1:0]   prod, dividend;
    logic [lrwg_pkg::DVS_W-1:0]   divisor;
    logic [lrwg_pkg::REM_W-1:0]   trial;
    logic                         trial_ge;

    // ---------------- item decode and state update ----------------
    assign kind_counted = (i_io_kind == lrwg_pkg::KIND_READ) ||
                          (i_io_kind == lrwg_pkg::KIND_WRITE);

    assign rd_sum = (TOTAL_BITS+1)'(r_rd_tot) + (TOTAL_BITS+1)'(i_io_bytes);
    assign wr_sum = (TOTAL_BITS+1)'(r_wr_tot) + (TOTAL_BITS+1)'(i_io_bytes);
    assign rd_sat = rd_sum[TOTAL_BITS] ? '1 : rd_sum[TOTAL_BITS-1:0];
    assign wr_sat = wr_sum[TOTAL_BITS] ? '1 : wr_sum[TOTAL_BITS-1:0];

    assign hit  = (r_rd_tot[TOTAL_BITS-1:lrwg_pkg::KB_SHIFT] >= KB_W'(r_thr)) ||
                  (r_wr_tot[TOTAL_BITS-1:lrwg_pkg::KB_SHIFT] >= KB_W'(r_thr));
    assign pick = hit ? r_max_gen : r_min_gen;

    assign o_sts.need_div = (i_opcode == lrwg_pkg::OP_IO) && r_gov_on &&
                            kind_counted && !r_armed;

    always_comb begin
        n_rd_tot  = r_rd_tot;
        n_wr_tot  = r_wr_tot;
        n_cur_gen = r_cur_gen;
        n_tgt_gen = r_tgt_gen;
        n_gov_on  = r_gov_on;
        n_armed   = r_armed;
        n_phase   = r_phase;
        n_thr     = r_thr;
        req       = 1'b0;
        req_gen   = r_tgt_gen;
        if (i_cmd.accept) begin
            case (i_opcode)
                lrwg_pkg::OP_IO: begin
                    // arming is finished later by the threshold sequence
                    if (r_gov_on && kind_counted) begin
                        if (i_io_kind == lrwg_pkg::KIND_READ) begin
                            n_rd_tot = rd_sat;
                        end else begin
                            n_wr_tot = wr_sat;
                        end
                    end
                end
                lrwg_pkg::OP_TICK: begin
                    if (r_armed) begin
                        if (!r_gov_on) begin
                            n_armed = 1'b0;
                        end else begin
                            n_rd_tot = '0;
                            n_wr_tot = '0;
                            if ((r_phase != lrwg_pkg::PH_RETRAIN) &&
                                (r_phase != lrwg_pkg::PH_ROLLBACK)) begin
                                n_tgt_gen = pick;
                                if (pick != r_cur_gen) begin
                                    req     = 1'b1;
                                    req_gen = pick;
                                    n_phase = lrwg_pkg::PH_RETRAIN;
                                end
                            end
                        end
                    end
                end
                lrwg_pkg::OP_OUTCOME: begin
                    case (r_phase)
                        lrwg_pkg::PH_RETRAIN: begin
                            if (i_retrain_ok) begin
                                n_cur_gen = r_tgt_gen;
                                n_phase   = lrwg_pkg::PH_IDLE;
                            end else begin
                                req     = 1'b1;
                                req_gen = r_cur_gen;
                                n_phase = lrwg_pkg::PH_ROLLBACK;
                            end
                        end
                        lrwg_pkg::PH_ROLLBACK: begin
                            if (!i_retrain_ok) begin
                                n_gov_on = 1'b0;
                            end
                            n_phase = lrwg_pkg::PH_IDLE;
                        end
                        default: begin
                        end
                    endcase
                end
                lrwg_pkg::OP_START: begin
                    if (r_gov_on) begin
                        n_armed = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.finish) begin
            n_thr   = r_cfg_ok ? r_quo : '0;
            n_armed = (n_thr != '0);
        end
    end

    // ---------------- threshold preparation ----------------
    assign min_ok  = (r_min_gen >= lrwg_pkg::GEN_LO) && (r_min_gen <= lrwg_pkg::GEN_HI);
    assign max_ok  = (r_max_gen >= lrwg_pkg::GEN_LO) && (r_max_gen <= lrwg_pkg::GEN_HI);
    assign lane_ok = (r_lane <= lrwg_pkg::LANE_MAX);
    assign min_idx  = min_ok  ? r_min_gen - lrwg_pkg::GEN_LO : '0;
    assign max_idx  = max_ok  ? r_max_gen - lrwg_pkg::GEN_LO : '0;
    assign lane_idx = lane_ok ? r_lane : '0;

    assign bw_lo   = lrwg_pkg::BW_TABLE[min_idx][lane_idx];
    assign bw_hi   = lrwg_pkg::BW_TABLE[max_idx][lane_idx];
    assign bw_diff = bw_hi - bw_lo;

    assign o_sts.cfg_ok = min_ok && max_ok && lane_ok && (bw_lo < bw_hi);

    assign prod     = lrwg_pkg::DVD_W'(bw_lo) * lrwg_pkg::DVD_W'(bw_hi);
    assign divisor  = lrwg_pkg::DVS_W'(bw_diff) *
                      lrwg_pkg::DVS_W'(lrwg_pkg::RETRAIN_SCALE);
    // rounding: add half the divisor before dividing
    assign dividend = prod + lrwg_pkg::DVD_W'(divisor >> 1);

    // restoring divider step; the quotient is known to fit THR_W bits,
    // so the upper dividend bits start as the partial remainder
    assign trial    = {r_rem[lrwg_pkg::REM_W-2:0], r_dvd_lo[lrwg_pkg::THR_W-1]};
    assign trial_ge = (trial >= lrwg_pkg::REM_W'(r_dvs));

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_rem    <= lrwg_pkg::REM_W'(dividend[lrwg_pkg::DVD_W-1:lrwg_pkg::THR_W]);
            r_dvd_lo <= dividend[lrwg_pkg::THR_W-1:0];
            r_dvs    <= divisor;
            r_quo    <= '0;
            r_cfg_ok <= o_sts.cfg_ok;
        end else if (i_cmd.div_step) begin
            r_rem    <= trial_ge ? trial - lrwg_pkg::REM_W'(r_dvs) : trial;
            r_dvd_lo <= {r_dvd_lo[lrwg_pkg::THR_W-2:0], 1'b0};
            r_quo    <= {r_quo[lrwg_pkg::THR_W-2:0], trial_ge};
        end
    end

    // ---------------- state registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_gen <= lrwg_pkg::RESET_MIN_GEN;
            r_max_gen <= lrwg_pkg::RESET_MAX_GEN;
            r_lane    <= lrwg_pkg::RESET_LANE;
            r_rd_tot  <= '0;
            r_wr_tot  <= '0;
            r_cur_gen <= lrwg_pkg::RESET_MAX_GEN;
            r_tgt_gen <= lrwg_pkg::RESET_MAX_GEN;
            r_gov_on  <= (lrwg_pkg::RESET_THR != '0);
            r_armed   <= 1'b0;
            r_phase   <= lrwg_pkg::PH_IDLE;
            r_thr     <= lrwg_pkg::RESET_THR;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    lrwg_pkg::REG_MIN_GEN: r_min_gen <= i_cfg_data;
                    lrwg_pkg::REG_MAX_GEN: r_max_gen <= i_cfg_data;
                    lrwg_pkg::REG_LANE:    r_lane    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_rd_tot  <= n_rd_tot;
            r_wr_tot  <= n_wr_tot;
            r_cur_gen <= n_cur_gen;
            r_tgt_gen <= n_tgt_gen;
            r_gov_on  <= n_gov_on;
            r_armed   <= n_armed;
            r_phase   <= n_phase;
            r_thr     <= n_thr;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_req     <= req;
            r_o_req_gen <= req ? req_gen : n_tgt_gen;
            r_o_cur_gen <= n_cur_gen;
            r_o_act     <= n_gov_on;
            r_o_win     <= n_armed;
            r_o_thr     <= n_thr;
        end
    end

    assign o_switch_request  = r_o_req;
    assign o_request_gen     = r_o_req_gen;
    assign o_current_gen_out = r_o_cur_gen;
    assign o_active_flag     = r_o_act;
    assign o_window_flag     = r_o_win;
    assign o_threshold_kb    = r_o_thr;

endmodule

/* design/lrwg_checker.sv */
// ----------------------------------------------------------------------------
// lrwg_checker
// Port-level checks of the governor, bound to the top level.
// ----------------------------------------------------------------------------
module lrwg_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic                            i_switch_request,
    input  logic [lrwg_pkg::GEN_W-1:0]      i_request_gen,
    input  logic [lrwg_pkg::GEN_W-1:0]      i_current_gen_out,
    input  logic                            i_active_flag,
    input  logic                            i_window_flag,
    input  logic [lrwg_pkg::THR_W-1:0]      i_threshold_kb
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid &&
            $stable(i_switch_request) && $stable(i_request_gen) &&
            $stable(i_current_gen_out) && $stable(i_active_flag) &&
            $stable(i_window_flag) && $stable(i_threshold_kb))
        else $error("stalled result changed");

    // no item is taken while an untaken result would be overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |-> !(i_out_valid && !i_out_ready))
        else $error("item accepted over a pending result");

    // threshold never exceeds the table maximum
    a_thr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_threshold_kb <= lrwg_pkg::THR_MAX)
        else $error("threshold out of range");

    // a disabled governor makes no retraining requests
    a_off_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_active_flag |-> !i_switch_request)
        else $error("request while disabled");

    // once disabled, only reset re-enables
    a_off_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_active_flag |=>
            !(i_out_valid && i_active_flag))
        else $error("governor re-enabled without reset");

endmodule

bind link_rate_workload_governor lrwg_checker u_lrwg_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_switch_request  (o_out.switch_request),
    .i_request_gen     (o_out.request_gen),
    .i_current_gen_out (o_out.current_gen_out),
    .i_active_flag     (o_out.active_flag),
    .i_window_flag     (o_out.window_flag),
    .i_threshold_kb    (o_out.threshold_kb)
);

/* tb/sv/link_rate_workload_governor_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// link_rate_workload_governor_tb
// Self-checking bench for the link-rate governor. It drives I/O, tick, outcome
// and start items, keeps its own model of the governor, and compares every
// status item with the value that model predicts. A short directed part is
// followed by random window sequences, setting changes, back-pressure and a
// final rollback failure that switches the governor off.
// ----------------------------------------------------------------------------
module link_rate_workload_governor_tb;
    import lrwg_pkg::*;

    localparam int SUM_W         = TOTAL_BITS_DEF;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 24;        // lets a running arming pass end
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_REPORTS   = 10;
    localparam int DRAIN_LIMIT   = 200000;
    localparam int TIMEOUT_NS    = 5_000_000;

    localparam logic [KIND_W-1:0]    KIND_OTHER = 2'd2;   // not counted
    localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd3;   // no register behind it

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [KIND_W-1:0]   io_kind;
        logic [BYTES_W-1:0]  io_bytes;
        logic                retrain_ok;
    } io_event_t;

    typedef struct packed {
        logic             switch_request;
        logic [GEN_W-1:0] request_gen;
        logic [GEN_W-1:0] current_gen;
        logic             active;
        logic             window;
        logic [THR_W-1:0] threshold;
    } gov_status_t;

    // ------------------------------------------------------------------------
    // Clock, reset and channels
    // ------------------------------------------------------------------------
    bit   i_clk;
    logic i_rst_n;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    lrwg_in_if  in_ch ();
    lrwg_res_if status_ch ();
    lrwg_cfg_if cfg_ch ();

    link_rate_workload_governor u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (status_ch),
        .i_cfg   (cfg_ch)
    );

    // ------------------------------------------------------------------------
    // Model of the governor: settings, totals, generations and phase
    // ------------------------------------------------------------------------
    logic [GEN_W-1:0]  set_min_gen;
    logic [GEN_W-1:0]  set_max_gen;
    logic [LANE_W-1:0] set_lane;
    logic [SUM_W-1:0]  read_sum;
    logic [SUM_W-1:0]  write_sum;
    logic [GEN_W-1:0]  gen_now;
    logic [GEN_W-1:0]  gen_goal;
    bit                gov_enabled;
    bit                win_open;
    logic [1:0]        retrain_phase;
    logic [THR_W-1:0]  kb_limit;

    gov_status_t awaited_status [$];

    int unsigned items_sent;
    int unsigned mismatch_count;
    int          tx_idle_pct;
    int          rx_idle_pct;
    logic        rx_held = 1'b0;
    event        hold_off_kick;

    // round(lo*hi / (10*(hi-lo))) from the bandwidth table, 0 when unusable
    function automatic logic [THR_W-1:0] kb_threshold(logic [GEN_W-1:0]  g_lo,
                                                      logic [GEN_W-1:0]  g_hi,
                                                      logic [LANE_W-1:0] lane);
        longint unsigned bw_lo, bw_hi, num, den;
        if (g_lo < GEN_LO || g_lo > GEN_HI || g_hi < GEN_LO || g_hi > GEN_HI ||
            lane > LANE_MAX) begin
            return '0;
        end
        bw_lo = BW_TABLE[g_lo - GEN_LO][lane];
        bw_hi = BW_TABLE[g_hi - GEN_LO][lane];
        if (bw_lo >= bw_hi) begin
            return '0;
        end
        num = bw_lo * bw_hi;
        den = RETRAIN_SCALE * (bw_hi - bw_lo);
        return THR_W'((num + den / 2) / den);
    endfunction

    function automatic logic [SUM_W-1:0] add_saturating(logic [SUM_W-1:0]   acc,
                                                        logic [BYTES_W-1:0] add);
        logic [SUM_W:0] sum;
        sum = {1'b0, acc} + add;
        return sum[SUM_W] ? {SUM_W{1'b1}} : sum[SUM_W-1:0];
    endfunction

    function automatic void reset_governor();
        set_min_gen   = RESET_MIN_GEN;
        set_max_gen   = RESET_MAX_GEN;
        set_lane      = RESET_LANE;
        read_sum      = '0;
        write_sum     = '0;
        gen_now       = RESET_MAX_GEN;
        gen_goal      = RESET_MAX_GEN;
        kb_limit      = kb_threshold(set_min_gen, set_max_gen, set_lane);
        gov_enabled   = kb_limit != '0;
        win_open      = 1'b0;
        retrain_phase = PH_IDLE;
    endfunction

    function automatic void store_setting(logic [CFG_IDX_W-1:0]  idx,
                                          logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_MIN_GEN: set_min_gen = val;
            REG_MAX_GEN: set_max_gen = val;
            REG_LANE:    set_lane    = val;
            default: ;
        endcase
    endfunction

    // Applies one accepted item and returns the status item it should produce
    function automatic gov_status_t advance_governor(io_event_t ev);
        gov_status_t      st;
        logic [GEN_W-1:0] choice;
        bit               asked;
        logic [GEN_W-1:0] asked_gen;
        asked     = 1'b0;
        asked_gen = '0;
        case (ev.opcode)
            OP_IO: begin
                if (gov_enabled && ev.io_kind <= KIND_WRITE) begin
                    if (ev.io_kind == KIND_READ) begin
                        read_sum = add_saturating(read_sum, ev.io_bytes);
                    end else begin
                        write_sum = add_saturating(write_sum, ev.io_bytes);
                    end
                    // the first counted request arms the window if the threshold is nonzero
                    if (!win_open) begin
                        kb_limit = kb_threshold(set_min_gen, set_max_gen, set_lane);
                        win_open = kb_limit != '0;
                    end
                end
            end
            OP_TICK: begin
                if (win_open) begin
                    if (!gov_enabled) begin
                        win_open = 1'b0;
                    end else begin
                        choice = ((read_sum >> KB_SHIFT) >= kb_limit ||
                                  (write_sum >> KB_SHIFT) >= kb_limit) ? set_max_gen
                                                                       : set_min_gen;
                        read_sum  = '0;
                        write_sum = '0;
                        // a retraining in flight keeps its target
                        if (retrain_phase != PH_RETRAIN && retrain_phase != PH_ROLLBACK) begin
                            gen_goal = choice;
                            if (gen_goal != gen_now) begin
                                asked         = 1'b1;
                                asked_gen     = gen_goal;
                                retrain_phase = PH_RETRAIN;
                            end
                        end
                    end
                end
            end
            OP_OUTCOME: begin
                if (retrain_phase == PH_RETRAIN) begin
                    if (ev.retrain_ok) begin
                        gen_now       = gen_goal;
                        retrain_phase = PH_IDLE;
                    end else begin
                        asked         = 1'b1;
                        asked_gen     = gen_now;
                        retrain_phase = PH_ROLLBACK;
                    end
                end else if (retrain_phase == PH_ROLLBACK) begin
                    if (!ev.retrain_ok) begin
                        gov_enabled = 1'b0;
                    end
                    retrain_phase = PH_IDLE;
                end
            end
            default: begin
                if (gov_enabled) begin
                    win_open = 1'b1;
                end
            end
        endcase
        st.switch_request = asked;
        st.request_gen    = asked ? asked_gen : gen_goal;
        st.current_gen    = gen_now;
        st.active         = gov_enabled;
        st.window         = win_open;
        st.threshold      = kb_limit;
        return st;
    endfunction

    // ------------------------------------------------------------------------
    // Status receiver: random ready, long hold-off on request, checking
    // ------------------------------------------------------------------------
    task automatic report_status(gov_status_t got);
        gov_status_t want;
        bit          bad;
        if (awaited_status.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
                $display("%0t: status item with none awaited (req=%0d gen=%0d cur=%0d)",
                         $time, got.switch_request, got.request_gen, got.current_gen);
            end
            return;
        end
        want = awaited_status.pop_front();
        bad  = got.switch_request !== want.switch_request ||
               got.request_gen    !== want.request_gen    ||
               got.current_gen    !== want.current_gen    ||
               got.active         !== want.active         ||
               got.window         !== want.window         ||
               got.threshold      !== want.threshold;
        if (bad) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
                $display("%0t: status mismatch req/gen/cur/on/win/thr exp %0d/%0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d/%0d",
                         $time, want.switch_request, want.request_gen, want.current_gen,
                         want.active, want.window, want.threshold,
                         got.switch_request, got.request_gen, got.current_gen,
                         got.active, got.window, got.threshold);
            end
        end
    endtask

    initial begin
        gov_status_t got;
        status_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && status_ch.valid && status_ch.ready) begin
                got.switch_request = status_ch.switch_request;
                got.request_gen    = status_ch.request_gen;
                got.current_gen    = status_ch.current_gen_out;
                got.active         = status_ch.active_flag;
                got.window         = status_ch.window_flag;
                got.threshold      = status_ch.threshold_kb;
                report_status(got);
            end
            status_ch.ready <= !rx_held && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Long receiver hold-off so that the block fills and stalls its input
    initial begin
        int unsigned held;
        forever begin
            @(hold_off_kick);
            rx_held <= 1'b1;
            for (held = 0; held < HOLD_CYCLES; held++) begin
                @(posedge i_clk);
            end
            rx_held <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Item and register drivers
    // ------------------------------------------------------------------------
    // valid stays high after acceptance; a settle, or an idle gap in the next offer, lowers it
    task automatic offer_event(logic [OPCODE_W-1:0] op, logic [KIND_W-1:0] kind,
                               logic [BYTES_W-1:0] bytes, logic ok);
        io_event_t   ev;
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct && gap < 40) begin
            gap++;
        end
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.opcode     <= op;
        in_ch.io_kind    <= kind;
        in_ch.io_bytes   <= bytes;
        in_ch.retrain_ok <= ok;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        ev.opcode     = op;
        ev.io_kind    = kind;
        ev.io_bytes   = bytes;
        ev.retrain_ok = ok;
        awaited_status.push_back(advance_governor(ev));
        items_sent++;
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) begin
            @(posedge i_clk);
        end
        store_setting(idx, val);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop offering, wait for every status item, then let the arming pass end
    task automatic settle_governor();
        int unsigned waited;
        in_ch.valid <= 1'b0;
        waited = 0;
        @(posedge i_clk);
        while (awaited_status.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // never fail a rollback before the final test: that would end the run's use
    function automatic logic safe_ok();
        if (retrain_phase == PH_ROLLBACK) begin
            return 1'b1;
        end
        return $urandom_range(3) != 0;
    endfunction

    function automatic logic [BYTES_W-1:0] rand_bytes(int unsigned span);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 4) begin
            return '0;
        end else if (pick < 8) begin
            return {BYTES_W{1'b1}};
        end else if (pick < 18) begin
            return $urandom;
        end
        return $urandom_range(span);
    endfunction

    // mostly legal generations, now and then an out-of-range one
    function automatic logic [GEN_W-1:0] pick_gen();
        if ($urandom_range(99) < 85) begin
            return GEN_W'($urandom_range(GEN_HI, GEN_LO));
        end
        return GEN_W'($urandom_range(7));
    endfunction

    task automatic stray_event();
        logic [OPCODE_W-1:0] op;
        op = OPCODE_W'($urandom_range(3));
        offer_event(op, KIND_W'($urandom_range(2)), rand_bytes(1 << 24),
                    (op == OP_OUTCOME) ? safe_ok() : 1'($urandom));
    endtask

    // A window: some traffic, a tick, then the retraining it may start
    task automatic random_window();
        int unsigned       n_io;
        int unsigned       span;
        logic [KIND_W-1:0] kind;
        n_io = $urandom_range(6, 1);
        span = ((kb_limit == '0) ? 8 : kb_limit) * 2048 / n_io;
        repeat (n_io) begin
            case ($urandom_range(9))
                0:          kind = KIND_OTHER;
                1, 2, 3, 4: kind = KIND_WRITE;
                default:    kind = KIND_READ;
            endcase
            offer_event(OP_IO, kind, rand_bytes(span), 1'($urandom));
        end
        offer_event(OP_TICK, KIND_W'($urandom_range(2)), $urandom, 1'($urandom));
        if (retrain_phase == PH_RETRAIN) begin
            if ($urandom_range(4) == 0) begin
                stray_event();
            end
            offer_event(OP_OUTCOME, KIND_W'($urandom_range(2)), $urandom, safe_ok());
            if (retrain_phase == PH_ROLLBACK) begin
                if ($urandom_range(3) == 0) begin
                    stray_event();
                end
                offer_event(OP_OUTCOME, KIND_W'($urandom_range(2)), $urandom, 1'b1);
            end
        end
    endtask

    task automatic shuffle_settings();
        settle_governor();
        write_register(REG_MIN_GEN, pick_gen());
        write_register(REG_MAX_GEN, pick_gen());
        write_register(REG_LANE, LANE_W'($urandom_range(7)));
        if ($urandom_range(3) == 0) begin
            write_register(REG_SPARE, CFG_DATA_W'($urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Start straight after reset: arms with the reset threshold, no recompute
    task automatic test_start_from_reset();
        offer_event(OP_START, KIND_READ, '0, 1'b0);
    endtask

    // Tick, then two outcomes: ignored unless a start from reset armed the window
    task automatic test_ignored_events();
        offer_event(OP_TICK, KIND_READ, '0, 1'b0);
        offer_event(OP_OUTCOME, KIND_WRITE, {BYTES_W{1'b1}}, 1'b0);
        offer_event(OP_OUTCOME, KIND_OTHER, '0, 1'b1);
    endtask

    // Each kind of unusable setting: recompute gives 0, window stays unarmed
    task automatic test_invalid_settings();
        settle_governor();
        write_register(REG_MIN_GEN, 3'd0);
        offer_event(OP_IO, KIND_READ, '0, 1'b1);
        settle_governor();
        write_register(REG_MIN_GEN, 3'd7);
        offer_event(OP_IO, KIND_WRITE, {BYTES_W{1'b1}}, 1'b0);
        settle_governor();
        write_register(REG_MIN_GEN, GEN_LO);
        write_register(REG_MAX_GEN, 3'd6);
        offer_event(OP_IO, KIND_READ, $urandom, 1'b1);
        settle_governor();
        write_register(REG_MAX_GEN, GEN_HI);
        write_register(REG_LANE, 3'd5);
        offer_event(OP_IO, KIND_WRITE, $urandom, 1'b0);
        settle_governor();
        write_register(REG_LANE, 3'd7);
        offer_event(OP_IO, KIND_READ, $urandom, 1'b1);
        // equal and inverted generations: min bandwidth not below max
        settle_governor();
        write_register(REG_LANE, RESET_LANE);
        write_register(REG_MIN_GEN, 3'd3);
        write_register(REG_MAX_GEN, 3'd3);
        offer_event(OP_IO, KIND_WRITE, $urandom, 1'b0);
        settle_governor();
        write_register(REG_MAX_GEN, 3'd2);
        write_register(REG_SPARE, 3'd5);
        offer_event(OP_IO, KIND_READ, $urandom, 1'b1);
        offer_event(OP_IO, KIND_OTHER, {BYTES_W{1'b1}}, 1'b1);
    endtask

    // Arming, both sides of the threshold, rollback success, tick mid-retrain
    task automatic test_window_decisions();
        logic [LANE_W-1:0]  lane;
        logic [BYTES_W-1:0] limit_bytes;
        lane = LANE_W'($urandom_range(LANE_MAX));
        settle_governor();
        write_register(REG_MIN_GEN, GEN_LO);
        write_register(REG_MAX_GEN, 3'd4);
        write_register(REG_LANE, lane);
        offer_event(OP_IO, KIND_READ, '0, 1'b0);
        limit_bytes = kb_limit * KB_DIV;
        // one byte short of the threshold on both sides: minimum generation
        offer_event(OP_IO, KIND_READ, limit_bytes - 1, 1'b1);
        offer_event(OP_IO, KIND_WRITE, limit_bytes - 1, 1'b0);
        offer_event(OP_TICK, KIND_READ, '0, 1'b0);
        offer_event(OP_OUTCOME, KIND_READ, '0, retrain_phase != PH_RETRAIN);
        offer_event(OP_OUTCOME, KIND_READ, '0, 1'b1);
        // exactly the threshold: maximum generation
        offer_event(OP_IO, KIND_WRITE, limit_bytes, 1'b1);
        offer_event(OP_TICK, KIND_WRITE, {BYTES_W{1'b1}}, 1'b1);
        offer_event(OP_TICK, KIND_OTHER, '0, 1'b0);
        offer_event(OP_IO, KIND_READ, {BYTES_W{1'b1}}, 1'b0);
        offer_event(OP_OUTCOME, KIND_OTHER, '0, 1'b1);
        offer_event(OP_START, KIND_OTHER, {BYTES_W{1'b1}}, 1'b1);
        offer_event(OP_TICK, KIND_READ, '0, 1'b0);
        offer_event(OP_OUTCOME, KIND_READ, '0, retrain_phase == PH_ROLLBACK);
    endtask

    task automatic test_random_traffic(int unsigned count);
        int unsigned goal;
        int unsigned next_shuffle;
        goal         = items_sent + count;
        next_shuffle = items_sent + 200;
        while (items_sent < goal) begin
            if ($urandom_range(9) < 8) begin
                random_window();
            end else begin
                stray_event();
            end
            if (items_sent >= next_shuffle) begin
                shuffle_settings();
                next_shuffle = items_sent + 200;
            end
        end
    endtask

    // Receiver holds off while items keep coming
    task automatic test_back_pressure();
        -> hold_off_kick;
        repeat (12) random_window();
    endtask

    // Failed retraining then failed rollback: governor off, then all ignored
    task automatic test_rollback_failure();
        settle_governor();
        write_register(REG_MIN_GEN, GEN_LO);
        write_register(REG_MAX_GEN, GEN_HI);
        while (retrain_phase != PH_IDLE) begin
            offer_event(OP_OUTCOME, KIND_READ, '0, 1'b1);
        end
        if (!win_open) begin
            offer_event(OP_START, KIND_READ, '0, 1'b0);
        end
        offer_event(OP_TICK, KIND_READ, '0, 1'b0);
        if (retrain_phase != PH_RETRAIN) begin
            // steer the next tick away from the current generation
            if (gen_now != GEN_HI) begin
                offer_event(OP_IO, KIND_READ, {BYTES_W{1'b1}}, 1'b1);
            end
            offer_event(OP_TICK, KIND_WRITE, '0, 1'b0);
        end
        offer_event(OP_OUTCOME, KIND_READ, '0, 1'b0);
        offer_event(OP_OUTCOME, KIND_WRITE, '0, 1'b0);
        offer_event(OP_IO, KIND_READ, {BYTES_W{1'b1}}, 1'b1);
        offer_event(OP_START, KIND_WRITE, '0, 1'b1);
        offer_event(OP_TICK, KIND_READ, '0, 1'b0);
        offer_event(OP_TICK, KIND_READ, '0, 1'b1);
        offer_event(OP_IO, KIND_WRITE, {BYTES_W{1'b1}}, 1'b0);
        offer_event(OP_START, KIND_READ, '0, 1'b0);
        offer_event(OP_OUTCOME, KIND_OTHER, '0, 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.opcode     <= OP_IO;
        in_ch.io_kind    <= KIND_READ;
        in_ch.io_bytes   <= '0;
        in_ch.retrain_ok <= 1'b0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= REG_MIN_GEN;
        cfg_ch.data      <= '0;
        items_sent     = 0;
        mismatch_count = 0;
        tx_idle_pct    = 28;
        rx_idle_pct    = 82;
        reset_governor();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // one seed in four arms the window by a start before any traffic
        if ($urandom_range(3) == 0) begin
            test_start_from_reset();
        end
        test_ignored_events();
        test_invalid_settings();
        test_window_decisions();
        test_random_traffic(620);

        shuffle_settings();
        tx_idle_pct = 82;
        rx_idle_pct = 28;
        test_random_traffic(620);

        shuffle_settings();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_back_pressure();
        test_random_traffic(520);
        test_rollback_failure();

        settle_governor();
        if (mismatch_count == 0 && awaited_status.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* files.f */
design/lrwg_pkg.sv
design/lrwg_if.sv
design/lrwg_ctrl.sv
design/lrwg_dp.sv
design/link_rate_workload_governor.sv
design/lrwg_checker.sv
tb/sv/link_rate_workload_governor_tb.sv
